// ===== rtl/char_lcd_nibble_writer_defines.svh =====
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

// same-cycle implication, checked after reset
`define CLNW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("char_lcd_nibble_writer check failed");

// next-cycle implication, checked after reset
`define CLNW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("char_lcd_nibble_writer check failed");

`endif

// ===== rtl/clnw_pkg.sv =====
`default_nettype none
package clnw_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int CFG_W       = 20;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [7:0] CLEAR_INSTR = 8'h01;

    localparam logic [1:0] REG_PULSE = 2'd0;
    localparam logic [1:0] REG_INSTR = 2'd1;
    localparam logic [1:0] REG_DATA  = 2'd2;
    localparam logic [1:0] REG_CLEAR = 2'd3;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_INSTR = 3'd1;
    localparam logic [2:0] CMD_DATA  = 3'd2;
    localparam logic [2:0] CMD_INIT  = 3'd3;
    localparam logic [2:0] CMD_LIGHT = 3'd4;

    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_TICK  = 3'd1;
    localparam logic [2:0] CLS_INSTR = 3'd2;
    localparam logic [2:0] CLS_DATA  = 3'd3;
    localparam logic [2:0] CLS_INIT  = 3'd4;
    localparam logic [2:0] CLS_LIGHT = 3'd5;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HI_EN  = 3'd1;
    localparam logic [2:0] PH_HI_GAP = 3'd2;
    localparam logic [2:0] PH_LO_EN  = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;
    localparam logic [2:0] PH_CLEAR  = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_ticks;
        logic [CFG_W-1:0] instr_wait_ticks;
        logic [CFG_W-1:0] data_wait_ticks;
        logic [CFG_W-1:0] clear_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_len(input logic [CFG_W-1:0] len,
                                                       input logic zero_as_one);
        logic [31:0] wide;
        wide = 32'(len);
        if (zero_as_one && (len == '0)) begin
            wide = 32'd1;
        end
        if (wide > CNT_MAX) begin
            return {COUNT_WIDTH{1'b1}};
        end
        return wide[COUNT_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/clnw_regs.sv =====
`default_nettype none
module clnw_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [clnw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [clnw_pkg::DATA_W-1:0]   pwdata,
    output logic      [clnw_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output clnw_pkg::cfg_t                     cfg
);

    clnw_pkg::cfg_t cfg_reg;
    clnw_pkg::cfg_t cfg_next;
    logic [clnw_pkg::CFG_W-1:0] wdata;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wdata  = pwdata[clnw_pkg::CFG_W-1:0];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                clnw_pkg::REG_PULSE: cfg_next.pulse_ticks      = wdata;
                clnw_pkg::REG_INSTR: cfg_next.instr_wait_ticks = wdata;
                clnw_pkg::REG_DATA:  cfg_next.data_wait_ticks  = wdata;
                clnw_pkg::REG_CLEAR: cfg_next.clear_wait_ticks = wdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            clnw_pkg::REG_PULSE: prdata = clnw_pkg::DATA_W'(cfg_reg.pulse_ticks);
            clnw_pkg::REG_INSTR: prdata = clnw_pkg::DATA_W'(cfg_reg.instr_wait_ticks);
            clnw_pkg::REG_DATA:  prdata = clnw_pkg::DATA_W'(cfg_reg.data_wait_ticks);
            clnw_pkg::REG_CLEAR: prdata = clnw_pkg::DATA_W'(cfg_reg.clear_wait_ticks);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ticks      <= clnw_pkg::CFG_W'(1);
            cfg_reg.instr_wait_ticks <= clnw_pkg::CFG_W'(45);
            cfg_reg.data_wait_ticks  <= clnw_pkg::CFG_W'(50);
            cfg_reg.clear_wait_ticks <= clnw_pkg::CFG_W'(1600);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clnw_front.sv =====
`default_nettype none
module clnw_front (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [7:0]         s_value,
    input  wire clnw_pkg::q_status_t q_status,
    output logic                    push,
    output clnw_pkg::item_t         push_item
);

    logic [2:0] cls;

    always_comb begin
        unique case (s_cmd)
            clnw_pkg::CMD_TICK:  cls = clnw_pkg::CLS_TICK;
            clnw_pkg::CMD_INSTR: cls = clnw_pkg::CLS_INSTR;
            clnw_pkg::CMD_DATA:  cls = clnw_pkg::CLS_DATA;
            clnw_pkg::CMD_INIT:  cls = clnw_pkg::CLS_INIT;
            clnw_pkg::CMD_LIGHT: cls = clnw_pkg::CLS_LIGHT;
            default:             cls = clnw_pkg::CLS_NONE;
        endcase
    end

    assign s_ready         = !q_status.full;
    assign push            = s_valid && !q_status.full;
    assign push_item.cls   = cls;
    assign push_item.value = s_value;

endmodule
`default_nettype wire

// ===== rtl/clnw_queue.sv =====
`default_nettype none
module clnw_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire clnw_pkg::item_t    push_item,
    input  wire logic               pop,
    output clnw_pkg::item_t         pop_item,
    output clnw_pkg::q_status_t     q_status
);

    localparam int PTR_W = (clnw_pkg::QUEUE_DEPTH > 1) ? $clog2(clnw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(clnw_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(clnw_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(clnw_pkg::QUEUE_DEPTH);

    clnw_pkg::item_t  slot_reg [clnw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign q_status.full  = (count_reg == FULL);
    assign q_status.empty = (count_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clnw_back.sv =====
`default_nettype none
module clnw_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire clnw_pkg::cfg_t     cfg,
    input  wire clnw_pkg::q_status_t q_status,
    input  wire clnw_pkg::item_t    pop_item,
    output logic                    pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_data_nibble,
    output logic                    m_enable_pin,
    output logic                    m_reg_select,
    output logic                    m_read_write,
    output logic                    m_data_drive,
    output logic                    m_backlight_pin,
    output logic                    m_busy_res,
    output logic                    m_rejected
);

    localparam int CW = clnw_pkg::COUNT_WIDTH;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    byte_reg, byte_next;
    logic          sel_reg, sel_next;
    logic          nib_only_reg, nib_only_next;
    logic          light_reg, light_next;

    logic          m_valid_reg, m_valid_next;
    logic [3:0]    nibble_reg, nibble_next;
    logic          en_reg, en_next;
    logic          drive_reg, drive_next;
    logic          rej_reg, rej_next;

    logic [CW-1:0] pulse_len, settle_len, clear_len, cnt_dec;
    logic          idle;

    assign pulse_len  = clnw_pkg::sat_len(cfg.pulse_ticks, 1'b1);
    assign settle_len = clnw_pkg::sat_len(sel_reg ? cfg.data_wait_ticks
                                                  : cfg.instr_wait_ticks, 1'b1);
    assign clear_len  = clnw_pkg::sat_len(cfg.clear_wait_ticks, 1'b0);
    assign cnt_dec    = (cnt_reg != '0) ? cnt_reg - CW'(1) : cnt_reg;
    assign idle       = (phase_reg == clnw_pkg::PH_IDLE);

    assign pop = !q_status.empty && (!m_valid_reg || m_ready);

    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        byte_next     = byte_reg;
        sel_next      = sel_reg;
        nib_only_next = nib_only_reg;
        light_next    = light_reg;
        rej_next      = 1'b0;
        unique case (pop_item.cls)
            clnw_pkg::CLS_TICK: begin
                if (!idle) begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0) begin
                        unique case (phase_reg)
                            clnw_pkg::PH_HI_EN: begin
                                phase_next = clnw_pkg::PH_HI_GAP;
                                cnt_next   = pulse_len;
                            end
                            clnw_pkg::PH_HI_GAP: begin
                                phase_next = clnw_pkg::PH_LO_EN;
                                cnt_next   = pulse_len;
                            end
                            clnw_pkg::PH_LO_EN: begin
                                phase_next = clnw_pkg::PH_SETTLE;
                                cnt_next   = settle_len;
                            end
                            clnw_pkg::PH_SETTLE: begin
                                if (!nib_only_reg && !sel_reg
                                    && byte_reg == clnw_pkg::CLEAR_INSTR
                                    && cfg.clear_wait_ticks != '0) begin
                                    phase_next = clnw_pkg::PH_CLEAR;
                                    cnt_next   = clear_len;
                                end else begin
                                    phase_next = clnw_pkg::PH_IDLE;
                                    cnt_next   = '0;
                                end
                            end
                            default: begin
                                phase_next = clnw_pkg::PH_IDLE;
                                cnt_next   = '0;
                            end
                        endcase
                    end
                end
            end
            clnw_pkg::CLS_INSTR, clnw_pkg::CLS_DATA: begin
                if (!idle) begin
                    rej_next = 1'b1;
                end else begin
                    byte_next     = pop_item.value;
                    sel_next      = (pop_item.cls == clnw_pkg::CLS_DATA);
                    nib_only_next = 1'b0;
                    phase_next    = clnw_pkg::PH_HI_EN;
                    cnt_next      = pulse_len;
                end
            end
            clnw_pkg::CLS_INIT: begin
                if (!idle) begin
                    rej_next = 1'b1;
                end else begin
                    byte_next     = {4'h0, pop_item.value[3:0]};
                    sel_next      = 1'b0;
                    nib_only_next = 1'b1;
                    phase_next    = clnw_pkg::PH_LO_EN;
                    cnt_next      = pulse_len;
                end
            end
            clnw_pkg::CLS_LIGHT: begin
                light_next = pop_item.value[0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        nibble_next = 4'h0;
        en_next     = 1'b0;
        drive_next  = 1'b0;
        if (phase_next == clnw_pkg::PH_HI_EN || phase_next == clnw_pkg::PH_HI_GAP) begin
            nibble_next = byte_next[7:4];
            drive_next  = 1'b1;
            en_next     = (phase_next == clnw_pkg::PH_HI_EN);
        end else if (phase_next == clnw_pkg::PH_LO_EN) begin
            nibble_next = byte_next[3:0];
            drive_next  = 1'b1;
            en_next     = 1'b1;
        end
    end

    always_comb begin
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= clnw_pkg::PH_IDLE;
            cnt_reg      <= '0;
            byte_reg     <= '0;
            sel_reg      <= 1'b0;
            nib_only_reg <= 1'b0;
            light_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg    <= phase_next;
                cnt_reg      <= cnt_next;
                byte_reg     <= byte_next;
                sel_reg      <= sel_next;
                nib_only_reg <= nib_only_next;
                light_reg    <= light_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            nibble_reg <= nibble_next;
            en_reg     <= en_next;
            drive_reg  <= drive_next;
            rej_reg    <= rej_next;
        end
    end

    logic sel_out_reg, light_out_reg, busy_out_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            sel_out_reg   <= sel_next;
            light_out_reg <= light_next;
            busy_out_reg  <= (phase_next != clnw_pkg::PH_IDLE);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data_nibble   = nibble_reg;
    assign m_enable_pin    = en_reg;
    assign m_reg_select    = sel_out_reg;
    assign m_read_write    = 1'b0;
    assign m_data_drive    = drive_reg;
    assign m_backlight_pin = light_out_reg;
    assign m_busy_res      = busy_out_reg;
    assign m_rejected      = rej_reg;

endmodule
`default_nettype wire

// ===== rtl/char_lcd_nibble_writer.sv =====
// Character LCD 4-bit write sequencer. Each word on the s_ side is a tick
// (cmd 0), a command (instruction byte, data byte, init nibble, backlight
// set) or an unused code that changes nothing, and each gives exactly one
// word on the m_ side showing the pin levels after it. One word is taken per
// clock: s_ready stays high while the two-entry queue between the decoder
// and the sequencer has room, and the result passes through the queue and
// then the output register. The sequencer updates its phase and tick counter
// once per word, so sustained throughput is one word per clock with m_ready
// held high. Timing registers (pulse, instruction settle, data settle, clear
// settle, in ticks) sit at byte addresses 0x0, 0x4, 0x8 and 0xC of the APB
// port and must only be written while no words are in flight.
`default_nettype none
module char_lcd_nibble_writer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [clnw_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [clnw_pkg::DATA_W-1:0]  pwdata,
    output logic      [clnw_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [2:0]                   s_cmd,
    input  wire logic [7:0]                   s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [3:0]                        m_data_nibble,
    output logic                              m_enable_pin,
    output logic                              m_reg_select,
    output logic                              m_read_write,
    output logic                              m_data_drive,
    output logic                              m_backlight_pin,
    output logic                              m_busy_res,
    output logic                              m_rejected
);

    clnw_pkg::cfg_t      cfg;
    clnw_pkg::q_status_t q_status;
    clnw_pkg::item_t     push_item;
    clnw_pkg::item_t     pop_item;
    logic                push;
    logic                pop;

    clnw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clnw_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_value   (s_value),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    clnw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    clnw_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_status        (q_status),
        .pop_item        (pop_item),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_nibble   (m_data_nibble),
        .m_enable_pin    (m_enable_pin),
        .m_reg_select    (m_reg_select),
        .m_read_write    (m_read_write),
        .m_data_drive    (m_data_drive),
        .m_backlight_pin (m_backlight_pin),
        .m_busy_res      (m_busy_res),
        .m_rejected      (m_rejected)
    );

endmodule
`default_nettype wire

// ===== rtl/clnw_checker.sv =====
`default_nettype none
`include "char_lcd_nibble_writer_defines.svh"
module clnw_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [3:0] m_data_nibble,
    input wire logic       m_enable_pin,
    input wire logic       m_data_drive,
    input wire logic       m_read_write,
    input wire logic       m_busy_res,
    input wire logic       m_rejected
);

    `CLNW_ASSERT_NOW(a_strobe_needs_drive, m_valid && m_enable_pin, m_data_drive)
    `CLNW_ASSERT_NOW(a_released_lines_low, m_valid && !m_data_drive, m_data_nibble == 4'h0)
    `CLNW_ASSERT_NOW(a_reject_only_busy, m_valid && m_rejected, m_busy_res)
    `CLNW_ASSERT_NOW(a_idle_not_driven, m_valid && !m_busy_res, !m_data_drive && !m_read_write)
    `CLNW_ASSERT_NEXT(a_stall_holds_word, m_valid && !m_ready, m_valid && $stable(m_data_nibble))

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_nibble (m_data_nibble),
    .m_enable_pin  (m_enable_pin),
    .m_data_drive  (m_data_drive),
    .m_read_write  (m_read_write),
    .m_busy_res    (m_busy_res),
    .m_rejected    (m_rejected)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import clnw_pkg::*;

    localparam logic [2:0]  CMD_SPARE5  = 3'd5;
    localparam logic [2:0]  CMD_SPARE6  = 3'd6;
    localparam logic [2:0]  CMD_SPARE7  = 3'd7;
    localparam logic [19:0] LEN_MAX     = 20'hFFFFF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SHOW_MAX    = 10;

    typedef struct packed {
        logic [3:0] nibble;
        logic       enable;
        logic       rs;
        logic       rw;
        logic       drive;
        logic       light;
        logic       busy;
        logic       rej;
    } lcd_pins_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  value;
        int unsigned reps;
        logic        typed;
        lcd_pins_t   pins;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [2:0]          s_cmd;
    logic [7:0]          s_value;
    logic                m_valid;
    logic                m_ready;
    logic [3:0]          m_data_nibble;
    logic                m_enable_pin;
    logic                m_reg_select;
    logic                m_read_write;
    logic                m_data_drive;
    logic                m_backlight_pin;
    logic                m_busy_res;
    logic                m_rejected;

    char_lcd_nibble_writer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_nibble   (m_data_nibble),
        .m_enable_pin    (m_enable_pin),
        .m_reg_select    (m_reg_select),
        .m_read_write    (m_read_write),
        .m_data_drive    (m_data_drive),
        .m_backlight_pin (m_backlight_pin),
        .m_busy_res      (m_busy_res),
        .m_rejected      (m_rejected)
    );

    always #10 aclk = ~aclk;

    // timing registers as last written
    logic [19:0] cfg_pulse;
    logic [19:0] cfg_instr;
    logic [19:0] cfg_data;
    logic [19:0] cfg_clear;

    // sequencer copy
    logic [2:0]  lcd_phase;
    logic [19:0] ticks_left;
    logic [7:0]  held_byte;
    logic        held_rs;
    logic        init_only;
    logic        light_level;

    lcd_pins_t   pin_levels_q [$];

    int          bad_words     = 0;
    int          words_in      = 0;
    int          live_words    = 0;
    int          cycle_cnt     = 0;
    int          stall_left    = 0;
    bit          long_hold_done = 1'b0;
    bit          calm          = 1'b0;

    dir_row_t dir_tab [24] = '{
        '{CMD_LIGHT,  8'h01, 1, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_TICK,   8'h00, 1, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_SPARE5, 8'hFF, 1, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_SPARE7, 8'h00, 1, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{CMD_INSTR,  8'hFF, 1, 1'b1, '{4'hF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{CMD_DATA,   8'h00, 1, 1'b1, '{4'hF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{CMD_LIGHT,  8'hFE, 1, 1'b1, '{4'hF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{CMD_INIT,   8'h0F, 1, 1'b1, '{4'hF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{CMD_TICK,   8'h00, 7, 1'b0, '0},
        '{CMD_DATA,   8'h00, 1, 1'b0, '0},
        '{CMD_TICK,   8'hFF, 8, 1'b0, '0},
        '{CMD_INIT,   8'hFF, 1, 1'b0, '0},
        '{CMD_TICK,   8'h00, 4, 1'b0, '0},
        '{CMD_INIT,   8'h01, 1, 1'b0, '0},
        '{CMD_TICK,   8'h00, 4, 1'b0, '0},
        '{CMD_INSTR,  8'h01, 1, 1'b0, '0},
        '{CMD_TICK,   8'h00, 10, 1'b0, '0},
        '{CMD_INSTR,  8'h10, 1, 1'b0, '0},
        '{CMD_TICK,   8'h00, 6, 1'b0, '0},
        '{CMD_DATA,   8'h01, 1, 1'b0, '0},
        '{CMD_TICK,   8'h00, 7, 1'b0, '0},
        '{CMD_LIGHT,  8'h01, 1, 1'b0, '0},
        '{CMD_SPARE6, 8'hAA, 1, 1'b0, '0},
        '{CMD_LIGHT,  8'h00, 1, 1'b0, '0}
    };

    function automatic logic [19:0] nonzero_len(input logic [19:0] len);
        return (len == '0) ? 20'd1 : len;
    endfunction

    function automatic void enter_phase(input logic [2:0] ph);
        lcd_phase = ph;
        case (ph)
            PH_HI_EN, PH_HI_GAP, PH_LO_EN: begin
                ticks_left = nonzero_len(cfg_pulse);
            end
            PH_SETTLE: begin
                ticks_left = nonzero_len(held_rs ? cfg_data : cfg_instr);
            end
            PH_CLEAR: begin
                ticks_left = cfg_clear;
            end
            default: begin
                lcd_phase  = PH_IDLE;
                ticks_left = '0;
            end
        endcase
    endfunction

    function automatic void next_phase();
        case (lcd_phase)
            PH_HI_EN:  enter_phase(PH_HI_GAP);
            PH_HI_GAP: enter_phase(PH_LO_EN);
            PH_LO_EN:  enter_phase(PH_SETTLE);
            PH_SETTLE: begin
                if (!init_only && !held_rs && held_byte == CLEAR_INSTR && cfg_clear != '0) begin
                    enter_phase(PH_CLEAR);
                end else begin
                    enter_phase(PH_IDLE);
                end
            end
            default:   enter_phase(PH_IDLE);
        endcase
    endfunction

    function automatic lcd_pins_t step_lcd(input logic [2:0] cmd, input logic [7:0] value);
        lcd_pins_t pins;
        pins = '0;
        if (cmd == CMD_TICK) begin
            if (lcd_phase != PH_IDLE) begin
                if (ticks_left != '0) ticks_left = ticks_left - 20'd1;
                if (ticks_left == '0) next_phase();
            end
        end else if (cmd == CMD_INSTR || cmd == CMD_DATA || cmd == CMD_INIT) begin
            if (lcd_phase != PH_IDLE) begin
                pins.rej = 1'b1;
            end else if (cmd == CMD_INIT) begin
                held_byte = {4'h0, value[3:0]};
                held_rs   = 1'b0;
                init_only = 1'b1;
                enter_phase(PH_LO_EN);
            end else begin
                held_byte = value;
                held_rs   = (cmd == CMD_DATA);
                init_only = 1'b0;
                enter_phase(PH_HI_EN);
            end
        end else if (cmd == CMD_LIGHT) begin
            light_level = value[0];
        end
        if (lcd_phase == PH_HI_EN || lcd_phase == PH_HI_GAP) begin
            pins.nibble = held_byte[7:4];
            pins.drive  = 1'b1;
            pins.enable = (lcd_phase == PH_HI_EN);
        end else if (lcd_phase == PH_LO_EN) begin
            pins.nibble = held_byte[3:0];
            pins.drive  = 1'b1;
            pins.enable = 1'b1;
        end
        pins.rs    = held_rs;
        pins.rw    = 1'b0;
        pins.light = light_level;
        pins.busy  = (lcd_phase != PH_IDLE);
        return pins;
    endfunction

    task automatic send_word(input logic [2:0] cmd, input logic [7:0] value,
                             input logic typed = 1'b0, input lcd_pins_t pins = '0);
        bit        ignored;
        lcd_pins_t want;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ignored = (cmd > CMD_LIGHT) || (cmd == CMD_TICK && lcd_phase == PH_IDLE);
        want = step_lcd(cmd, value);
        pin_levels_q.push_back(typed ? pins : want);
        words_in++;
        if (!ignored) live_words++;
    endtask

    task automatic drain_words();
        s_valid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {12'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PULSE: cfg_pulse = val;
            REG_INSTR: cfg_instr = val;
            REG_DATA:  cfg_data  = val;
            default:   cfg_clear = val;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_timing(input logic [19:0] pulse, input logic [19:0] instr,
                              input logic [19:0] data, input logic [19:0] clear);
        drain_words();
        write_reg(REG_PULSE, pulse);
        write_reg(REG_INSTR, instr);
        write_reg(REG_DATA, data);
        write_reg(REG_CLEAR, clear);
    endtask

    task automatic run_phase(input int quota);
        int         stop_at;
        int         pick;
        logic [2:0] cmd;
        logic [7:0] value;
        stop_at = live_words + quota;
        while (live_words < stop_at) begin
            if ($urandom_range(0, 99) < 80) begin
                pick  = $urandom_range(0, 9);
                cmd   = (pick < 4) ? CMD_INSTR : (pick < 8) ? CMD_DATA : CMD_INIT;
                value = 8'($urandom);
                if (cmd == CMD_INSTR && $urandom_range(0, 3) == 0) value = CLEAR_INSTR;
                send_word(cmd, value);
                while (lcd_phase != PH_IDLE) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) begin
                        send_word(CMD_TICK, 8'($urandom));
                    end else if (pick < 90) begin
                        send_word(CMD_LIGHT, 8'($urandom));
                    end else if (pick < 97) begin
                        send_word(3'($urandom_range(CMD_INSTR, CMD_INIT)), 8'($urandom));
                    end else begin
                        send_word(3'($urandom_range(CMD_SPARE5, CMD_SPARE7)), 8'($urandom));
                    end
                end
            end else begin
                send_word(3'($urandom), 8'($urandom));
            end
        end
    endtask

    always @(posedge aclk) begin : check_out
        lcd_pins_t got;
        lcd_pins_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_data_nibble, m_enable_pin, m_reg_select, m_read_write,
                   m_data_drive, m_backlight_pin, m_busy_res, m_rejected};
            if (pin_levels_q.size() == 0) begin
                if (bad_words < SHOW_MAX) $display("unexpected word: %h", got);
                bad_words++;
            end else begin
                want = pin_levels_q.pop_front();
                if (got !== want) begin
                    if (bad_words < SHOW_MAX) begin
                        $display("mismatch: nib %h/%h en %b/%b rs %b/%b rw %b/%b drv %b/%b",
                                 want.nibble, got.nibble, want.enable, got.enable,
                                 want.rs, got.rs, want.rw, got.rw, want.drive, got.drive);
                        $display("          bl %b/%b busy %b/%b rej %b/%b (want/got)",
                                 want.light, got.light, want.busy, got.busy,
                                 want.rej, got.rej);
                    end
                    bad_words++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!long_hold_done && words_in >= 300) begin
            long_hold_done <= 1'b1;
            stall_left     <= 300;
            m_ready        <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_valid = 1'b0;
        s_cmd   = CMD_TICK;
        s_value = '0;
        m_ready = 1'b0;

        cfg_pulse   = 20'd1;
        cfg_instr   = 20'd45;
        cfg_data    = 20'd50;
        cfg_clear   = 20'd1600;
        lcd_phase   = PH_IDLE;
        ticks_left  = '0;
        held_byte   = '0;
        held_rs     = 1'b0;
        init_only   = 1'b0;
        light_level = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_timing(20'd1, 20'd2, 20'd3, 20'd4);
        foreach (dir_tab[r]) begin
            repeat (dir_tab[r].reps) send_word(dir_tab[r].cmd, dir_tab[r].value,
                                               dir_tab[r].typed, dir_tab[r].pins);
        end

        set_timing(20'd1, 20'd45, 20'd50, 20'd1600);
        run_phase(250);
        set_timing(20'd1, 20'd1, 20'd1, 20'd0);
        run_phase(150);
        set_timing(20'd0, 20'd0, 20'd0, 20'd0);
        run_phase(100);
        repeat (3) begin
            set_timing(20'($urandom_range(1, 4)), 20'($urandom_range(1, 8)),
                       20'($urandom_range(1, 8)), 20'($urandom_range(0, 10)));
            run_phase(200);
        end
        set_timing(20'd2, 20'd3, 20'd4, 20'd1);
        run_phase(150);

        calm = 1'b1;
        set_timing(20'd1, 20'd2, 20'd2, 20'd3);
        run_phase(150);

        // park in the longest clear wait, then push the rest to full scale
        set_timing(20'd2, 20'd1, LEN_MAX, LEN_MAX);
        send_word(CMD_INSTR, CLEAR_INSTR);
        while (lcd_phase != PH_CLEAR) send_word(CMD_TICK, 8'h00);
        repeat (25) send_word(CMD_TICK, 8'($urandom));
        send_word(CMD_DATA, 8'h5A);
        send_word(CMD_LIGHT, 8'h01);
        send_word(CMD_INIT, 8'h03);
        set_timing(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
        repeat (10) send_word(CMD_TICK, 8'($urandom));

        s_valid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pin_levels_q.size() != 0) bad_words++;
        if (bad_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
